// ===== hdl/corq_pkg.sv =====
// ----------------------------------------------------------------------------
// corq_pkg - shared types and codes for the credit ordered ready queue
// Item layouts for both channels, the per-cell entry and the control bundle
// that the top level broadcasts to the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package corq_pkg;

    // operation codes carried in the kind field
    localparam logic [2:0] KIND_INSERT    = 3'd0;
    localparam logic [2:0] KIND_POP_FRONT = 3'd1;
    localparam logic [2:0] KIND_POP_BACK  = 3'd2;
    localparam logic [2:0] KIND_FIND      = 3'd3;
    localparam logic [2:0] KIND_TAKE      = 3'd4;
    localparam logic [2:0] KIND_READ_AT   = 3'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] thread_id;
        logic [7:0]  credit;
        logic [7:0]  position;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [15:0] out_thread_id;
        logic [7:0]  out_credit;
        logic [4:0]  occupancy;
        logic        is_empty;
        logic        rejected;
    } rsp_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] thread_id;
        logic [7:0]  credit;
    } entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] thread_id;
        logic [7:0]  credit;
        logic [7:0]  position;
        logic        eval;
        logic        ins;
        logic        rm;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/corq_cell.sv =====
// ----------------------------------------------------------------------------
// corq_cell - one slot of the ordered queue
// Holds one entry, evaluates its own hit flag for the current operation and
// shifts data to or from its neighbors when the operation is applied.
// ----------------------------------------------------------------------------
`default_nettype none

module corq_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire corq_pkg::cell_ctrl_t ctrl,
    input  wire corq_pkg::entry_t    left_entry,
    input  wire logic                left_hit,
    input  wire corq_pkg::entry_t    right_entry,
    input  wire logic                seen_in,
    input  wire corq_pkg::entry_t    res_in,
    output corq_pkg::entry_t         entry,
    output logic                     hit,
    output logic                     seen_out,
    output corq_pkg::entry_t         res_out
);
    import corq_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [15:0] id_reg;
    logic [15:0] id_next;
    logic [7:0]  credit_reg;
    logic [7:0]  credit_next;
    logic        hit_reg;
    logic        hit_next;
    logic        first;

    assign entry = '{valid: valid_reg, thread_id: id_reg, credit: credit_reg};
    assign hit   = hit_reg;

    always_comb
    begin
        case (ctrl.kind)
            KIND_INSERT:    hit_next = valid_reg && (credit_reg >= ctrl.credit);
            KIND_POP_FRONT: hit_next = valid_reg && (INDEX == 0);
            KIND_POP_BACK:  hit_next = valid_reg && !right_entry.valid;
            KIND_FIND,
            KIND_TAKE:      hit_next = valid_reg && (id_reg == ctrl.thread_id);
            KIND_READ_AT:   hit_next = valid_reg && (ctrl.position == 8'(INDEX));
            default:        hit_next = 1'b0;
        endcase
    end

    // first hit in the row claims the result slot
    assign first    = hit_reg && !seen_in;
    assign seen_out = seen_in || hit_reg;
    assign res_out  = first ? entry : res_in;

    always_comb
    begin
        valid_next  = valid_reg;
        id_next     = id_reg;
        credit_next = credit_reg;
        if (ctrl.ins && !hit_reg)
        begin
            if (left_hit)
            begin
                valid_next  = 1'b1;
                id_next     = ctrl.thread_id;
                credit_next = ctrl.credit;
            end
            else
            begin
                valid_next  = left_entry.valid;
                id_next     = left_entry.thread_id;
                credit_next = left_entry.credit;
            end
        end
        else if (ctrl.rm && seen_out)
        begin
            // close the gap from the right
            valid_next  = right_entry.valid;
            id_next     = right_entry.thread_id;
            credit_next = right_entry.credit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.eval)
            begin
                hit_reg <= hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        credit_reg <= credit_next;
    end

endmodule

`default_nettype wire

// ===== hdl/credit_ordered_ready_queue_top.sv =====
// ----------------------------------------------------------------------------
// credit_ordered_ready_queue_top - thread ready queue in credit order
// Request channel (req_valid/req_ready/req) takes one operation item: insert
// in credit order, pop front, pop back, find id, take id or read at position.
// Response channel (rsp_valid/rsp_ready/rsp) returns exactly one item per
// request, in request order.
// Sequence: after a request is accepted the row of cells registers its hit flags
// in the ST_HIT state and shifts in the ST_APPLY state, which also loads the
// response register. A new request is taken in the cycle the previous one
// applies, so the block takes the next request while still finishing the last.
// The response sits in an output register; if rsp_ready is low, one more
// request can be accepted and waits in its apply step until the register
// frees up.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module credit_ordered_ready_queue_top #(
    parameter int DEPTH = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire corq_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output corq_pkg::rsp_t      rsp
);
    import corq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HIT,
        ST_APPLY
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    req_t               op_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    cell_ctrl_t         ctrl;
    entry_t             ent  [DEPTH];
    logic               hitv [DEPTH];
    logic               seen [DEPTH+1];
    entry_t             res  [DEPTH+1];
    logic [DEPTH-1:0]   valid_vec;

    logic               accept;
    logic               go;
    logic               full;
    logic               is_ins;
    logic               is_rm;
    logic               any_hit;
    logic               found;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign go        = (state_reg == ST_APPLY) && (!rsp_valid_reg || rsp_ready);
    assign req_ready = (state_reg == ST_IDLE) || go;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign is_ins  = (op_reg.kind == KIND_INSERT);
    assign is_rm   = (op_reg.kind inside {KIND_POP_FRONT, KIND_POP_BACK, KIND_TAKE});
    assign any_hit = seen[DEPTH];
    assign found   = any_hit && (op_reg.kind inside {KIND_POP_FRONT, KIND_POP_BACK,
                                                      KIND_FIND, KIND_TAKE, KIND_READ_AT});

    always_comb
    begin
        ctrl.kind      = op_reg.kind;
        ctrl.thread_id = op_reg.thread_id;
        ctrl.credit    = op_reg.credit;
        ctrl.position  = op_reg.position;
        ctrl.eval      = (state_reg == ST_HIT);
        ctrl.ins       = go && is_ins && !full;
        ctrl.rm        = go && is_rm && any_hit;
    end

    assign seen[0] = 1'b0;
    assign res[0]  = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_h;

        if (i == 0)
        begin : g_head
            assign left_e = '0;
            assign left_h = 1'b1;
        end
        else
        begin : g_body
            assign left_e = ent[i-1];
            assign left_h = hitv[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_mid
            assign right_e = ent[i+1];
        end

        corq_cell #(
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_entry  (left_e),
            .left_hit    (left_h),
            .right_entry (right_e),
            .seen_in     (seen[i]),
            .res_in      (res[i]),
            .entry       (ent[i]),
            .hit         (hitv[i]),
            .seen_out    (seen[i+1]),
            .res_out     (res[i+1])
        );

        assign valid_vec[i] = ent[i].valid;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_HIT;
                end
            end
            ST_HIT:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (go)
                begin
                    if (ctrl.ins)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if (ctrl.rm)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    rsp_valid_next         = 1'b1;
                    rsp_next.found         = found;
                    rsp_next.out_thread_id = found ? res[DEPTH].thread_id : 16'd0;
                    rsp_next.out_credit    = found ? res[DEPTH].credit : 8'd0;
                    rsp_next.occupancy     = 5'(count_next);
                    rsp_next.is_empty      = (count_next == '0);
                    rsp_next.rejected      = is_ins && full;
                    state_next             = accept ? ST_HIT : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= req;
        end
    end

    // the number of occupied cells matches the entry count
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == count_reg)
        else $error("cell valid bits disagree with entry count");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.is_empty == (count_reg == '0)))
        else $error("empty flag disagrees with entry count");

    a_no_accept_mid_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HIT) |-> !req_ready)
        else $error("request accepted during hit evaluation");

    a_reject_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (go && is_ins && full) |=> (rsp_reg.rejected && !rsp_reg.found))
        else $error("full insert not flagged as rejected");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - testbench for the credit ordered ready queue
// Sends directed and random queue operations through the request channel and
// checks each response, field by field, against a software copy of the queue
// that is updated as each request is accepted. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import corq_pkg::*;

    localparam int QDEPTH = 16;

    // unused kinds: the block must answer them without touching the queue
    localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

    // two copies of the queue: one follows accepted requests, one the plan
    localparam int LIVE = 0;
    localparam int PLAN = 1;

    typedef enum int { PH_MIXED, PH_FILL, PH_DRAIN } phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic [15:0] slot_id [2][QDEPTH];
    logic [7:0]  slot_credit [2][QDEPTH];
    int          slot_count [2] = '{0, 0};

    req_t pending_req [$];
    bit   pending_pause [$];
    rsp_t expected_rsp [$];

    int n_errors = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_hits = 0;
    int n_rejects = 0;
    int peak_occupancy = 0;
    int n_kind [8] = '{default: 0};
    int send_gap = 0;
    int recv_stall = 0;
    int recv_hold = 0;
    bit hold_done = 1'b0;

    credit_ordered_ready_queue_top #(
        .DEPTH(QDEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // a generous bound on the whole run
    initial
    begin
        #16_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic void drop_at(input int s, input int p);
        int i;
        for (i = p; i + 1 < slot_count[s]; i++)
        begin
            slot_id[s][i] = slot_id[s][i + 1];
            slot_credit[s][i] = slot_credit[s][i + 1];
        end
        slot_count[s]--;
    endfunction

    // applies one operation to queue copy s and returns its response
    function automatic rsp_t apply_op(input int s, input req_t r);
        rsp_t o;
        int p;
        int i;
        o = '0;
        p = 0;
        case (r.kind)
            KIND_INSERT:
            begin
                if (slot_count[s] >= QDEPTH)
                begin
                    o.rejected = 1'b1;
                end
                else
                begin
                    // behind every entry of equal or higher credit
                    while (p < slot_count[s] && slot_credit[s][p] >= r.credit)
                        p++;
                    for (i = slot_count[s]; i > p; i--)
                    begin
                        slot_id[s][i] = slot_id[s][i - 1];
                        slot_credit[s][i] = slot_credit[s][i - 1];
                    end
                    slot_id[s][p] = r.thread_id;
                    slot_credit[s][p] = r.credit;
                    slot_count[s]++;
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK:
            begin
                if (slot_count[s] > 0)
                begin
                    p = (r.kind == KIND_POP_FRONT) ? 0 : slot_count[s] - 1;
                    o.found = 1'b1;
                    o.out_thread_id = slot_id[s][p];
                    o.out_credit = slot_credit[s][p];
                    drop_at(s, p);
                end
            end
            KIND_FIND, KIND_TAKE:
            begin
                // nearest the front wins on repeated ids
                while (p < slot_count[s] && slot_id[s][p] != r.thread_id)
                    p++;
                if (p < slot_count[s])
                begin
                    o.found = 1'b1;
                    o.out_thread_id = slot_id[s][p];
                    o.out_credit = slot_credit[s][p];
                    if (r.kind == KIND_TAKE)
                        drop_at(s, p);
                end
            end
            KIND_READ_AT:
            begin
                if (int'(r.position) < slot_count[s])
                begin
                    o.found = 1'b1;
                    o.out_thread_id = slot_id[s][r.position];
                    o.out_credit = slot_credit[s][r.position];
                end
            end
            default:
            begin
            end
        endcase
        o.occupancy = 5'(slot_count[s]);
        o.is_empty = (slot_count[s] == 0);
        return o;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        else if (r < 92)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 50);
    endfunction

    task automatic queue_op(input logic [2:0] k, input logic [15:0] id,
                            input logic [7:0] cr, input logic [7:0] pos,
                            input bit pause);
        req_t item;
        item.kind = k;
        item.thread_id = id;
        item.credit = cr;
        item.position = pos;
        void'(apply_op(PLAN, item));
        pending_req.push_back(item);
        pending_pause.push_back(pause);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_rsp.push_back(apply_op(LIVE, req));
                n_kind[req.kind]++;
                n_accepted++;
            end
            if (!(req_valid && !req_ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_req.size() > 0 &&
                         !(pending_pause[0] && expected_rsp.size() > 0))
                begin
                    req <= pending_req.pop_front();
                    void'(pending_pause.pop_front());
                    req_valid <= 1'b1;
                    // no gaps while accepted count is in its calm window
                    if (((n_accepted / 200) % 4) != 1 && $urandom_range(0, 2) == 0)
                        send_gap = pick_gap();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            recv_stall = 0;
            recv_hold = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                n_results++;
                if (rsp.found)
                    n_hits++;
                if (rsp.rejected)
                    n_rejects++;
                if (int'(rsp.occupancy) > peak_occupancy)
                    peak_occupancy = int'(rsp.occupancy);
                if (expected_rsp.size() == 0)
                begin
                    $error("result with nothing expected: %p", rsp);
                    n_errors++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, rsp.found);
                        n_errors++;
                    end
                    if (rsp.out_thread_id !== want.out_thread_id)
                    begin
                        $error("out_thread_id: expected 0x%04h, got 0x%04h",
                               want.out_thread_id, rsp.out_thread_id);
                        n_errors++;
                    end
                    if (rsp.out_credit !== want.out_credit)
                    begin
                        $error("out_credit: expected %0d, got %0d",
                               want.out_credit, rsp.out_credit);
                        n_errors++;
                    end
                    if (rsp.occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, rsp.occupancy);
                        n_errors++;
                    end
                    if (rsp.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, got %0d",
                               want.is_empty, rsp.is_empty);
                        n_errors++;
                    end
                    if (rsp.rejected !== want.rejected)
                    begin
                        $error("rejected: expected %0d, got %0d",
                               want.rejected, rsp.rejected);
                        n_errors++;
                    end
                end
                // one long hold so the block fills and backs up its input
                if (n_results == 300 && !hold_done)
                begin
                    recv_hold = 60;
                    hold_done = 1'b1;
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                rsp_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (((n_results / 250) % 5) != 2 && $urandom_range(0, 3) == 0)
                    recv_stall = pick_gap();
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        phase_t phase;
        int n;
        int r;
        int insert_pct;
        logic [2:0] k;
        logic [15:0] id;
        logic [7:0] cr;
        logic [7:0] pos;

        // empty queue corner cases
        queue_op(KIND_POP_FRONT, 16'h0000, 8'h00, 8'h00, 1'b0);
        queue_op(KIND_POP_BACK, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
        queue_op(KIND_FIND, 16'h0000, 8'h00, 8'h00, 1'b0);
        queue_op(KIND_TAKE, 16'hFFFF, 8'h00, 8'h00, 1'b0);
        queue_op(KIND_READ_AT, 16'h0000, 8'h00, 8'h00, 1'b0);
        queue_op(KIND_UNUSED_LO, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
        queue_op(KIND_UNUSED_HI, 16'h0000, 8'h00, 8'h00, 1'b0);
        // extremes, equal credits and a repeated id
        queue_op(KIND_INSERT, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
        queue_op(KIND_INSERT, 16'h0000, 8'h00, 8'h00, 1'b0);
        queue_op(KIND_INSERT, 16'h1234, 8'h00, 8'h00, 1'b0);
        queue_op(KIND_INSERT, 16'hFFFF, 8'h80, 8'h00, 1'b0);
        queue_op(KIND_INSERT, 16'hA5A5, 8'hFF, 8'h00, 1'b0);
        queue_op(KIND_FIND, 16'hFFFF, 8'h00, 8'h00, 1'b0);
        queue_op(KIND_READ_AT, 16'h0000, 8'h00, 8'h00, 1'b0);
        queue_op(KIND_READ_AT, 16'h0000, 8'h00, 8'h04, 1'b0);
        queue_op(KIND_READ_AT, 16'h0000, 8'h00, 8'h05, 1'b0);
        queue_op(KIND_READ_AT, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
        queue_op(KIND_TAKE, 16'hFFFF, 8'h00, 8'h00, 1'b0);
        queue_op(KIND_FIND, 16'hFFFF, 8'h00, 8'h00, 1'b0);
        queue_op(KIND_TAKE, 16'h7777, 8'h00, 8'h00, 1'b0);
        queue_op(KIND_UNUSED_LO, 16'h0000, 8'h00, 8'h01, 1'b0);
        queue_op(KIND_POP_BACK, 16'h0000, 8'h00, 8'h00, 1'b0);
        queue_op(KIND_POP_FRONT, 16'h0000, 8'h00, 8'h00, 1'b0);

        // random part in phases that fill, drain or mix the queue
        phase = PH_MIXED;
        for (n = 0; n < 1500; n++)
        begin
            if (n % 40 == 0)
                phase = phase_t'($urandom_range(0, 2));
            insert_pct = (phase == PH_FILL) ? 70 : (phase == PH_DRAIN) ? 20 : 40;
            r = $urandom_range(0, 99);
            if (r < insert_pct)
                k = KIND_INSERT;
            else if (r >= 97)
                k = $urandom_range(0, 1) ? KIND_UNUSED_LO : KIND_UNUSED_HI;
            else
            begin
                case ($urandom_range(0, 4))
                    0: k = KIND_POP_FRONT;
                    1: k = KIND_POP_BACK;
                    2: k = KIND_FIND;
                    3: k = KIND_TAKE;
                    default: k = KIND_READ_AT;
                endcase
            end
            // ids held in the queue come back often, for hits and duplicates
            r = $urandom_range(0, 99);
            if (slot_count[PLAN] > 0 &&
                ((k == KIND_INSERT && r < 25) || (k != KIND_INSERT && r < 65)))
                id = slot_id[PLAN][$urandom_range(0, slot_count[PLAN] - 1)];
            else if ($urandom_range(0, 1))
                id = 16'($urandom_range(0, 15));
            else
                id = 16'($urandom_range(0, 65535));
            r = $urandom_range(0, 99);
            if (r < 50)
                cr = 8'($urandom_range(0, 255));
            else if (r < 80)
                cr = 8'($urandom_range(100, 103));
            else
                cr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            if ($urandom_range(0, 4) != 0)
                pos = 8'($urandom_range(0, QDEPTH + 1));
            else
                pos = 8'($urandom_range(0, 255));
            queue_op(k, id, cr, pos, (n == 700 || n == 1200));
        end

        @(posedge rst_n);
        while (pending_req.size() > 0 || req_valid || expected_rsp.size() > 0)
            @(negedge clk);
        repeat (10) @(posedge clk);

        $display("tb_top: %0d requests: %0d inserts, %0d front pops, %0d back pops,",
                 n_accepted, n_kind[KIND_INSERT], n_kind[KIND_POP_FRONT],
                 n_kind[KIND_POP_BACK]);
        $display("tb_top: %0d finds, %0d takes, %0d reads, %0d unused; %0d hits, %0d full,",
                 n_kind[KIND_FIND], n_kind[KIND_TAKE], n_kind[KIND_READ_AT],
                 n_kind[KIND_UNUSED_LO] + n_kind[KIND_UNUSED_HI], n_hits, n_rejects);
        $display("tb_top: peak occupancy %0d", peak_occupancy);
        if (n_errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
